// ===== src/bftt_pkg.sv =====
// shared types and constants for the bidirectional flow table tracker
package bftt_pkg;

	localparam int DEF_FLOW_SLOTS = 32;

	localparam logic [7:0]  RST_EXPORT_COUNT  = 8'd8;
	localparam logic [15:0] RST_IDLE_TIMEOUT  = 16'd30;
	localparam logic [15:0] RST_REPORT_PERIOD = 16'd10;

	localparam logic [1:0] REG_EXPORT_COUNT  = 2'd0;
	localparam logic [1:0] REG_IDLE_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_REPORT_PERIOD = 2'd2;

	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [3:0]  IP_VERSION_4   = 4'd4;
	localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
	localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;
	localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
	localparam logic [15:0] TCP_HDR_LEN    = 16'd20;
	localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
	localparam logic [47:0] BYTE_MAX       = 48'hFFFF_FFFF_FFFF;
	// slot field of results that concern no flow slot
	localparam logic [5:0]  NO_SLOT        = 6'h3F;

	typedef enum logic [2:0] {
		EV_COUNTED = 3'd0,
		EV_MALFORMED = 3'd1,
		EV_TABLE_FULL = 3'd2,
		EV_COUNT_EXPORT = 3'd3,
		EV_TIMEOUT_EXPORT = 3'd4,
		EV_SILENT_EVICT = 3'd5,
		EV_REPORT = 3'd6,
		EV_TICK_IDLE = 3'd7
	} event_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [31:0] ports;
		logic [7:0]  protocol;
		logic [7:0]  tally;
		logic        exported;
		logic [31:0] created;
		logic [31:0] seen;
	} entry_t;

	typedef struct packed {
		event_t      kind;
		logic        last;
		logic [5:0]  slot;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] from_port;
		logic [15:0] to_port;
		logic [7:0]  protocol;
		logic [7:0]  packets;
		logic [31:0] start;
		logic [47:0] bytes;
	} result_t;

endpackage

// ===== src/bftt_cell.sv =====
// one flow table slot in the rotating ring of slots
module bftt_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift,
	input  bftt_pkg::entry_t     d,
	output bftt_pkg::entry_t     q
);
	import bftt_pkg::*;

	logic   valid_q;
	entry_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	always_comb begin
		q = data_q;
		q.valid = valid_q;
	end

endmodule

// ===== src/bidirectional_flow_table_tracker.sv =====
// top level: flow table controller over a ring of slot cells
// Usage: one input channel (in_valid/in_ready) carries packet headers and
// one-second ticks; one output channel (out_valid/out_ready) carries result
// transactions, the last of each input item flagged by last_of_run.
// The slots sit in a ring of FLOW_SLOTS cells; in search, update and tick passes
// it rotates one place a cycle and the controller works on the slot at its head.
// A packet is handled in a check, one full rotation to search for a matching
// and a free slot, a decide step and a second rotation to update the chosen slot.
// Malformed packets and table-full packets finish after the check or search.
// A tick runs a bit-serial remainder of the second count by the report period,
// one rotation over the slots to evict idle flows, and then its final results.
// One item is in work at a time; in_ready is high only between items.
// Results go through one output register; when out_ready is low and a result is
// pending, the update and tick rotations stop until the pending result is taken.
// Reset empties the table, clears the second counter and byte count and
// loads default register values; configuration writes take effect at once.
module bidirectional_flow_table_tracker #(
	parameter int FLOW_SLOTS = bftt_pkg::DEF_FLOW_SLOTS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         req_type,
	input  logic [15:0]  frame_len,
	input  logic [3:0]   ip_version,
	input  logic [3:0]   ip_hdr_words,
	input  logic [7:0]   ip_protocol,
	input  logic [31:0]  src_addr,
	input  logic [31:0]  dst_addr,
	input  logic [15:0]  l4_src_port,
	input  logic [15:0]  l4_dst_port,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   event_kind,
	output logic         last_of_run,
	output logic [5:0]   slot_index,
	output logic [31:0]  flow_src_addr,
	output logic [31:0]  flow_dst_addr,
	output logic [15:0]  flow_src_port,
	output logic [15:0]  flow_dst_port,
	output logic [7:0]   flow_protocol,
	output logic [7:0]   flow_packets,
	output logic [31:0]  flow_start_second,
	output logic [47:0]  interval_bytes
);
	import bftt_pkg::*;

	localparam int SW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(FLOW_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_SCAN, S_DECIDE, S_UPDATE, S_DIV, S_TICK, S_TEND
	} state_t;

	state_t      state_q;
	logic [7:0]  export_count_q;
	logic [15:0] idle_timeout_q;
	logic [15:0] report_period_q;
	logic [31:0] now_q;
	logic [47:0] bytes_q;

	logic        bad_q;
	logic [7:0]  proto_q;
	logic [31:0] sa_q;
	logic [31:0] da_q;
	logic [15:0] sp_q;
	logic [15:0] dp_q;

	logic [SW-1:0] cnt_q;
	logic          found_q;
	logic [SW-1:0] found_slot_q;
	logic          free_q;
	logic [SW-1:0] free_slot_q;
	logic          alloc_q;
	logic [SW-1:0] target_q;

	logic [4:0]  div_cnt_q;
	logic [31:0] div_q;
	logic [15:0] rem_q;

	logic        pend_v_q;
	result_t     pend_q;

	logic        out_valid_q;
	result_t     out_q;

	entry_t      ring_q [FLOW_SLOTS];
	entry_t      head;
	entry_t      wb;
	entry_t      upd;
	logic        shift;
	logic        emit;
	result_t     emit_res;
	logic        can_emit;
	logic        match;
	logic        evict;
	logic        do_report;
	logic [7:0]  tally0;
	logic [7:0]  tally1;
	logic        export_now;
	logic [16:0] div_trial;
	logic [47:0] byte_sum;
	logic [15:0] minlen;
	logic        pkt_bad;
	logic        is_l4;
	result_t     evict_res;

	genvar gi;
	generate
		for (gi = 0; gi < FLOW_SLOTS; gi++) begin : g_ring
			if (gi == FLOW_SLOTS - 1) begin : g_tail
				bftt_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
					.d(wb), .q(ring_q[gi]));
			end else begin : g_mid
				bftt_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
					.d(ring_q[gi+1]), .q(ring_q[gi]));
			end
		end
	endgenerate

	assign head = ring_q[0];
	assign can_emit = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign do_report = (report_period_q == 16'd0) || (rem_q == 16'd0);

	always_comb begin
		minlen = ETH_HDR_LEN + {10'd0, ip_hdr_words, 2'b00};
		is_l4 = (ip_protocol == PROTO_TCP) || (ip_protocol == PROTO_UDP);
		pkt_bad = (frame_len < MIN_FRAME_LEN) || (ip_version != IP_VERSION_4) ||
			(ip_hdr_words < MIN_HDR_WORDS) || (frame_len < minlen) ||
			((ip_protocol == PROTO_TCP) && (frame_len < minlen + TCP_HDR_LEN)) ||
			((ip_protocol == PROTO_UDP) && (frame_len < minlen + UDP_HDR_LEN));
		byte_sum = bytes_q + {32'd0, frame_len};
		if (byte_sum < bytes_q) begin
			byte_sum = BYTE_MAX;
		end
		div_trial = {rem_q, div_q[31]};
	end

	always_comb begin
		match = head.valid && (head.protocol == proto_q) &&
			((head.src_addr == sa_q && head.dst_addr == da_q &&
			  head.ports == {sp_q, dp_q}) ||
			 (head.src_addr == da_q && head.dst_addr == sa_q &&
			  head.ports == {dp_q, sp_q}));
		evict = head.valid && ((now_q - head.seen) > {16'd0, idle_timeout_q});

		upd = head;
		if (alloc_q) begin
			upd.valid = 1'b1;
			upd.src_addr = sa_q;
			upd.dst_addr = da_q;
			upd.ports = {sp_q, dp_q};
			upd.protocol = proto_q;
			upd.exported = 1'b0;
			upd.created = now_q;
		end
		tally0 = alloc_q ? 8'd0 : head.tally;
		tally1 = (tally0 < export_count_q) ? tally0 + 8'd1 : tally0;
		export_now = !upd.exported && (tally1 >= export_count_q);
		upd.tally = tally1;
		upd.seen = now_q;
		if (export_now) begin
			upd.exported = 1'b1;
		end

		evict_res = '0;
		evict_res.kind = head.exported ? EV_SILENT_EVICT : EV_TIMEOUT_EXPORT;
		evict_res.slot = 6'(cnt_q);
		evict_res.src_addr = head.src_addr;
		evict_res.dst_addr = head.dst_addr;
		evict_res.from_port = head.ports[31:16];
		evict_res.to_port = head.ports[15:0];
		evict_res.protocol = head.protocol;
		evict_res.packets = head.tally;
		evict_res.start = head.created;

		wb = head;
		shift = 1'b0;
		emit = 1'b0;
		emit_res = '0;
		unique case (state_q)
			S_CHECK: begin
				if (bad_q) begin
					emit = can_emit;
					emit_res.kind = EV_MALFORMED;
					emit_res.last = 1'b1;
					emit_res.slot = NO_SLOT;
				end
			end
			S_SCAN: begin
				shift = 1'b1;
			end
			S_DECIDE: begin
				if (!found_q && !free_q) begin
					emit = can_emit;
					emit_res.kind = EV_TABLE_FULL;
					emit_res.last = 1'b1;
					emit_res.slot = NO_SLOT;
					emit_res.src_addr = sa_q;
					emit_res.dst_addr = da_q;
					emit_res.from_port = sp_q;
					emit_res.to_port = dp_q;
					emit_res.protocol = proto_q;
				end
			end
			S_UPDATE: begin
				shift = can_emit;
				if (cnt_q == target_q) begin
					wb = upd;
					emit = can_emit;
					emit_res.kind = export_now ? EV_COUNT_EXPORT : EV_COUNTED;
					emit_res.last = 1'b1;
					emit_res.slot = 6'(cnt_q);
					emit_res.src_addr = upd.src_addr;
					emit_res.dst_addr = upd.dst_addr;
					emit_res.from_port = upd.ports[31:16];
					emit_res.to_port = upd.ports[15:0];
					emit_res.protocol = upd.protocol;
					emit_res.packets = upd.tally;
					emit_res.start = upd.created;
				end
			end
			S_TICK: begin
				shift = can_emit;
				if (evict) begin
					wb.valid = 1'b0;
					if (pend_v_q) begin
						emit = can_emit;
						emit_res = pend_q;
					end
				end
			end
			S_TEND: begin
				emit = can_emit;
				if (pend_v_q) begin
					emit_res = pend_q;
					emit_res.last = !do_report;
				end else if (do_report) begin
					emit_res.kind = EV_REPORT;
					emit_res.last = 1'b1;
					emit_res.slot = NO_SLOT;
					emit_res.bytes = bytes_q;
				end else begin
					emit_res.kind = EV_TICK_IDLE;
					emit_res.last = 1'b1;
					emit_res.slot = NO_SLOT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			export_count_q <= RST_EXPORT_COUNT;
			idle_timeout_q <= RST_IDLE_TIMEOUT;
			report_period_q <= RST_REPORT_PERIOD;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_EXPORT_COUNT:  export_count_q <= cfg_data[7:0];
				REG_IDLE_TIMEOUT:  idle_timeout_q <= cfg_data;
				REG_REPORT_PERIOD: report_period_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			now_q <= '0;
			bytes_q <= '0;
			pend_v_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					pend_v_q <= 1'b0;
					if (in_valid) begin
						if (req_type) begin
							now_q <= now_q + 32'd1;
							state_q <= S_DIV;
						end else begin
							bytes_q <= byte_sum;
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (!bad_q) begin
						state_q <= S_SCAN;
					end else if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + SW'(1);
					if (cnt_q == LAST_SLOT) begin
						cnt_q <= '0;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (found_q || free_q) begin
						state_q <= S_UPDATE;
					end else if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				S_UPDATE: begin
					if (can_emit) begin
						cnt_q <= cnt_q + SW'(1);
						if (cnt_q == LAST_SLOT) begin
							cnt_q <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_DIV: begin
					if (div_cnt_q == 5'd31) begin
						state_q <= S_TICK;
					end
				end
				S_TICK: begin
					if (can_emit) begin
						if (evict) begin
							pend_v_q <= 1'b1;
						end
						cnt_q <= cnt_q + SW'(1);
						if (cnt_q == LAST_SLOT) begin
							cnt_q <= '0;
							state_q <= S_TEND;
						end
					end
				end
				S_TEND: begin
					if (can_emit) begin
						if (pend_v_q) begin
							pend_v_q <= 1'b0;
							if (!do_report) begin
								state_q <= S_IDLE;
							end
						end else begin
							if (do_report) begin
								bytes_q <= '0;
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			bad_q <= pkt_bad;
			proto_q <= ip_protocol;
			sa_q <= src_addr;
			da_q <= dst_addr;
			sp_q <= is_l4 ? l4_src_port : 16'd0;
			dp_q <= is_l4 ? l4_dst_port : 16'd0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			div_cnt_q <= '0;
			div_q <= now_q + 32'd1;
			rem_q <= '0;
		end
		if (state_q == S_SCAN) begin
			if (match && !found_q) begin
				found_q <= 1'b1;
				found_slot_q <= cnt_q;
			end
			if (!head.valid && !free_q) begin
				free_q <= 1'b1;
				free_slot_q <= cnt_q;
			end
		end
		if (state_q == S_DECIDE) begin
			alloc_q <= !found_q;
			target_q <= found_q ? found_slot_q : free_slot_q;
		end
		if (state_q == S_DIV) begin
			div_cnt_q <= div_cnt_q + 5'd1;
			div_q <= {div_q[30:0], 1'b0};
			if (div_trial >= {1'b0, report_period_q}) begin
				rem_q <= 16'(div_trial - {1'b0, report_period_q});
			end else begin
				rem_q <= div_trial[15:0];
			end
		end
		if (state_q == S_TICK && can_emit && evict) begin
			pend_q <= evict_res;
		end
	end

	assign out_valid = out_valid_q;
	assign event_kind = out_q.kind;
	assign last_of_run = out_q.last;
	assign slot_index = out_q.slot;
	assign flow_src_addr = out_q.src_addr;
	assign flow_dst_addr = out_q.dst_addr;
	assign flow_src_port = out_q.from_port;
	assign flow_dst_port = out_q.to_port;
	assign flow_protocol = out_q.protocol;
	assign flow_packets = out_q.packets;
	assign flow_start_second = out_q.start;
	assign interval_bytes = out_q.bytes;

endmodule
